[rtl/sbsl_pkg.sv]
// Package for the source block symbol layout block.
// Holds field widths, status codes, register indexes and the item structs.
// No dependencies.
`timescale 1ns / 1ps

package sbsl_pkg;

  localparam int TL_W  = 48;
  localparam int SL_W  = 16;
  localparam int MB_W  = 32;
  localparam int ID_W  = 16;
  localparam int ADR_W = 5;
  localparam int DAT_W = 64;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BLOCK_OOR = 2'd1;
  localparam logic [1:0] ST_SYM_OOR   = 2'd2;
  localparam logic [1:0] ST_BAD_CFG   = 2'd3;

  localparam logic [1:0] REG_TRANSFER = 2'd0;
  localparam logic [1:0] REG_SYMBOL   = 2'd1;
  localparam logic [1:0] REG_MAXBLOCK = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] block_number;
    logic [ID_W-1:0] symbol_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [TL_W-1:0] byte_offset;
    logic [SL_W-1:0] symbol_bytes;
    logic [MB_W-1:0] block_symbols;
    logic [TL_W-1:0] block_count;
    logic [TL_W-1:0] symbol_count;
    logic [TL_W-1:0] large_block_count;
  } out_item_t;

  // Partition figures handed from the configuration side to the query pipeline.
  typedef struct packed {
    logic            bad;
    logic [TL_W-1:0] t;
    logic [SL_W-1:0] e;
    logic [TL_W-1:0] n;
    logic [TL_W-1:0] z;
    logic [TL_W-1:0] zl;
    logic [MB_W-1:0] al;
    logic [MB_W-1:0] as_len;
  } part_t;

endpackage

[rtl/sbsl_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses sbsl_pkg for the operand width.
`timescale 1ns / 1ps

module sbsl_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sbsl_pkg::TL_W-1:0] dividend,
  input  logic [sbsl_pkg::TL_W-1:0] divisor,
  output logic                     done,
  output logic [sbsl_pkg::TL_W-1:0] quotient,
  output logic [sbsl_pkg::TL_W-1:0] remainder
);

  localparam int W   = sbsl_pkg::TL_W;
  localparam int CW  = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    shifted = {r_r, q_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, d_r};
    ge      = ~diff[W+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[W-2:0], ge};
      r_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

[rtl/sbsl_part.sv]
// Configuration registers and the sequencer that derives the partition figures.
// Uses sbsl_pkg and instantiates sbsl_div.
`timescale 1ns / 1ps

module sbsl_part (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbsl_pkg::ADR_W-1:0]  paddr,
  input  logic [sbsl_pkg::DAT_W-1:0]  pwdata,
  output logic [sbsl_pkg::DAT_W-1:0]  prdata,
  output logic                        busy,
  output sbsl_pkg::part_t             part
);

  localparam int TW = sbsl_pkg::TL_W;
  localparam int EW = sbsl_pkg::SL_W;
  localparam int BW = sbsl_pkg::MB_W;

  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_START = 3'd1;
  localparam logic [2:0] SQ_N     = 3'd2;
  localparam logic [2:0] SQ_Z     = 3'd3;
  localparam logic [2:0] SQ_A     = 3'd4;

  logic [TW-1:0] t_r;
  logic [EW-1:0] e_r;
  logic [BW-1:0] b_r;
  logic [2:0]    state_r, state_nxt;
  logic          bad_r, bad_nxt;
  logic [TW-1:0] n_r, n_nxt;
  logic [TW-1:0] z_r, z_nxt;
  logic [TW-1:0] zl_r, zl_nxt;
  logic [BW-1:0] al_r, al_nxt;
  logic [BW-1:0] as_r, as_nxt;
  logic          wr;
  logic [1:0]    idx;
  logic          div_start;
  logic [TW-1:0] div_a, div_b;
  logic          div_done;
  logic [TW-1:0] div_q, div_rem;
  logic [TW-1:0] q_ceil;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:3];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
      e_r <= '0;
      b_r <= '0;
    end else if (wr) begin
      unique case (idx)
        sbsl_pkg::REG_TRANSFER: t_r <= pwdata[TW-1:0];
        sbsl_pkg::REG_SYMBOL:   e_r <= pwdata[EW-1:0];
        sbsl_pkg::REG_MAXBLOCK: b_r <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (idx)
      sbsl_pkg::REG_TRANSFER: prdata = {{(sbsl_pkg::DAT_W-TW){1'b0}}, t_r};
      sbsl_pkg::REG_SYMBOL:   prdata = {{(sbsl_pkg::DAT_W-EW){1'b0}}, e_r};
      sbsl_pkg::REG_MAXBLOCK: prdata = {{(sbsl_pkg::DAT_W-BW){1'b0}}, b_r};
      default:                prdata = '0;
    endcase
  end

  sbsl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign q_ceil = div_q + {{(TW-1){1'b0}}, (div_rem != '0)};

  // Sequencer: N = ceil(T/E), Z = ceil(N/B), then N/Z gives AS, AL and ZL.
  always_comb begin
    state_nxt = state_r;
    bad_nxt   = bad_r;
    n_nxt     = n_r;
    z_nxt     = z_r;
    zl_nxt    = zl_r;
    al_nxt    = al_r;
    as_nxt    = as_r;
    div_start = 1'b0;
    div_a     = t_r;
    div_b     = {{(TW-EW){1'b0}}, e_r};
    unique case (state_r)
      SQ_IDLE: ;
      SQ_START: begin
        if ((t_r == '0) || (e_r == '0) || (b_r == '0)) begin
          bad_nxt   = 1'b1;
          state_nxt = SQ_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = SQ_N;
        end
      end
      SQ_N: begin
        div_a = q_ceil;
        div_b = {{(TW-BW){1'b0}}, b_r};
        if (div_done) begin
          n_nxt     = q_ceil;
          div_start = 1'b1;
          state_nxt = SQ_Z;
        end
      end
      SQ_Z: begin
        div_a = n_r;
        div_b = q_ceil;
        if (div_done) begin
          z_nxt     = q_ceil;
          div_start = 1'b1;
          state_nxt = SQ_A;
        end
      end
      SQ_A: begin
        if (div_done) begin
          as_nxt    = div_q[BW-1:0];
          al_nxt    = q_ceil[BW-1:0];
          zl_nxt    = div_rem;
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
    // Any write restarts the derivation.
    if (wr) begin
      state_nxt = SQ_START;
      bad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      bad_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      bad_r   <= bad_nxt;
    end
    n_r  <= n_nxt;
    z_r  <= z_nxt;
    zl_r <= zl_nxt;
    al_r <= al_nxt;
    as_r <= as_nxt;
  end

  assign busy        = (state_r != SQ_IDLE);
  assign part.bad    = bad_r;
  assign part.t      = t_r;
  assign part.e      = e_r;
  assign part.n      = n_r;
  assign part.z      = z_r;
  assign part.zl     = zl_r;
  assign part.al     = al_r;
  assign part.as_len = as_r;

endmodule

[rtl/sbsl_query.sv]
// Six-stage query pipeline: range checks, block start, symbol offset and length.
// Uses sbsl_pkg; partition figures come from sbsl_part.
`timescale 1ns / 1ps

module sbsl_query (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  sbsl_pkg::in_item_t  in_item,
  input  logic                out_stall,
  input  sbsl_pkg::part_t     part,
  output logic                adv,
  output logic                out_valid,
  output sbsl_pkg::out_item_t out_item
);

  localparam int TW = sbsl_pkg::TL_W;
  localparam int EW = sbsl_pkg::SL_W;
  localparam int BW = sbsl_pkg::MB_W;
  localparam int IW = sbsl_pkg::ID_W;
  localparam int HW = TW / 2;
  localparam int PW = HW + EW;

  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [1:0]    st1_r, st2_r, st3_r, st4_r, st5_r;
  logic [BW-1:0] bl1_r, bl2_r, bl3_r, bl4_r, bl5_r;
  logic [IW-1:0] bn1_r, sid1_r, sid2_r;
  logic [IW-1:0] mn1_r, mn2_r;
  logic [TW-1:0] prod2_r, g3_r, off5_r;
  logic [HW+EW-1:0] plo4_r, phi4_r;
  sbsl_pkg::out_item_t out_r;

  logic [1:0]    st1_nxt;
  logic [BW-1:0] bl1_nxt;
  logic [IW-1:0] mn1_nxt;
  logic          bn_lt_zl;
  logic [TW-1:0] rem6;
  logic [EW-1:0] sb6;

  assign adv = ~(v6_r & out_stall);

  // Stage one: range checks and the length of the named block.
  always_comb begin
    bn_lt_zl = ({{(TW-IW){1'b0}}, in_item.block_number} < part.zl);
    mn1_nxt  = bn_lt_zl ? in_item.block_number : part.zl[IW-1:0];
    bl1_nxt  = bn_lt_zl ? part.al : part.as_len;
    st1_nxt  = sbsl_pkg::ST_OK;
    if (part.bad) begin
      st1_nxt = sbsl_pkg::ST_BAD_CFG;
      bl1_nxt = '0;
    end else if ({{(TW-IW){1'b0}}, in_item.block_number} >= part.z) begin
      st1_nxt = sbsl_pkg::ST_BLOCK_OOR;
      bl1_nxt = '0;
    end else if ({{(BW-IW){1'b0}}, in_item.symbol_index} >= bl1_nxt) begin
      st1_nxt = sbsl_pkg::ST_SYM_OOR;
    end
  end

  // Stage six: bytes left from the offset, capped at the symbol length.
  always_comb begin
    rem6 = part.t - off5_r;
    sb6  = (rem6 < {{(TW-EW){1'b0}}, part.e}) ? rem6[EW-1:0] : part.e;
  end

  // Valid bits; the whole pipe holds while the output item is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Payload stages. The block start is bn*AS + min(bn, ZL).
  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r  <= st1_nxt;
      bl1_r  <= bl1_nxt;
      bn1_r  <= in_item.block_number;
      sid1_r <= in_item.symbol_index;
      mn1_r  <= mn1_nxt;

      st2_r   <= st1_r;
      bl2_r   <= bl1_r;
      sid2_r  <= sid1_r;
      mn2_r   <= mn1_r;
      prod2_r <= TW'(bn1_r) * TW'(part.as_len);

      st3_r <= st2_r;
      bl3_r <= bl2_r;
      g3_r  <= prod2_r + {{(TW-IW){1'b0}}, mn2_r} + {{(TW-IW){1'b0}}, sid2_r};

      st4_r  <= st3_r;
      bl4_r  <= bl3_r;
      plo4_r <= PW'(g3_r[HW-1:0]) * PW'(part.e);
      phi4_r <= PW'(g3_r[TW-1:HW]) * PW'(part.e);

      st5_r  <= st4_r;
      bl5_r  <= bl4_r;
      off5_r <= {{(TW-HW-EW){1'b0}}, plo4_r} + {phi4_r[TW-HW-1:0], {HW{1'b0}}};

      out_r.status        <= st5_r;
      out_r.block_symbols <= bl5_r;
      if (st5_r == sbsl_pkg::ST_OK) begin
        out_r.byte_offset  <= off5_r;
        out_r.symbol_bytes <= sb6;
      end else begin
        out_r.byte_offset  <= '0;
        out_r.symbol_bytes <= '0;
      end
      if (st5_r == sbsl_pkg::ST_BAD_CFG) begin
        out_r.block_count       <= '0;
        out_r.symbol_count      <= '0;
        out_r.large_block_count <= '0;
      end else begin
        out_r.block_count       <= part.z;
        out_r.symbol_count      <= part.n;
        out_r.large_block_count <= part.zl;
      end
    end
  end

  assign out_valid = v6_r;
  assign out_item  = out_r;

endmodule

[rtl/source_block_symbol_layout.sv]
// Top level of the source block symbol layout block.
// Uses sbsl_pkg; instantiates sbsl_part and sbsl_query.
//
// Usage: write the transfer length (0x00), the encoding symbol length (0x08)
// and the maximum block length (0x10) through the register port (64-bit data,
// writes at psel & penable & pwrite, pready always high). Each write starts a
// derivation of N, Z, AL, AS and ZL in a shared one-bit-per-cycle divider:
// three divisions, during which in_stall is high. A zero setting is caught in
// the start state instead, and no division runs.
// Queries enter on in_valid/in_stall as {block_number, symbol_index} items and
// leave on out_valid/out_stall, one result item per query.
// Items pass through the registered query pipeline; one item is accepted
// every cycle while in_stall is low.
// While a result waits under out_stall the whole pipeline holds and in_stall
// is raised, so nothing is lost or repeated.
// After reset the settings are zero, the configuration reads as bad and each
// query answers with the bad-config status.
`timescale 1ns / 1ps

module source_block_symbol_layout (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sbsl_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbsl_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbsl_pkg::ADR_W-1:0]  paddr,
  input  logic [sbsl_pkg::DAT_W-1:0]  pwdata,
  output logic [sbsl_pkg::DAT_W-1:0]  prdata,
  output logic                        pready
);

  sbsl_pkg::part_t part;
  logic            busy;
  logic            adv;

  assign pready   = 1'b1;
  assign in_stall = busy | ~adv;

  sbsl_part u_part (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .busy    (busy),
    .part    (part)
  );

  sbsl_query u_query (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_valid & ~in_stall),
    .in_item   (in_data),
    .out_stall (out_stall),
    .part      (part),
    .adv       (adv),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

[rtl/sbsl_checker.sv]
// Port-level checks for source_block_symbol_layout, with the bind that attaches them.
// Uses sbsl_pkg for status codes and item types.
`timescale 1ns / 1ps

module sbsl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sbsl_pkg::out_item_t out_data,
  input logic                psel,
  input logic                penable,
  input logic                pwrite
);

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // A register write closes the input; checked just after the write.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> in_stall)
    else $error("input open right after a register write");

  // Bad configuration zeroes the byte offset, block length, block count and symbol count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sbsl_pkg::ST_BAD_CFG |->
      out_data.byte_offset == '0 && out_data.block_symbols == '0 &&
      out_data.block_count == '0 && out_data.symbol_count == '0)
    else $error("bad-config item carries data");

  // A good symbol always has at least one byte and lies inside a real block.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sbsl_pkg::ST_OK |->
      out_data.symbol_bytes != '0 && out_data.block_symbols != '0)
    else $error("good item with empty symbol or block");

endmodule

bind source_block_symbol_layout sbsl_checker u_sbsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite)
);
